[rtl/core/sha256s_pkg.sv]
// sha256s_pkg: constants, tables and round functions of the sha-256 stream core
// no dependencies; imported by sha256_stream_hash_core
`timescale 1ns / 1ps

package sha256s_pkg;

    typedef logic [31:0] word_t;

    // input beat kinds carried on s_tuser
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned SCHED_WORDS = 16;
    localparam int unsigned CHAIN_WORDS = 8;
    localparam int unsigned LEN_START   = 56;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // initial chaining values
    localparam word_t INIT_HASH [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constants
    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror32(input word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t x);
        big_s0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic word_t big_s1(input word_t x);
        big_s1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic word_t small_s0(input word_t x);
        small_s0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_s1(input word_t x);
        small_s1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t ch_f(input word_t e, input word_t f, input word_t g);
        ch_f = (e & f) ^ (~e & g);
    endfunction

    function automatic word_t maj_f(input word_t a, input word_t b, input word_t c);
        maj_f = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

[rtl/core/sha256_stream_hash_core.sv]
// sha256_stream_hash_core: byte-stream sha-256 with one shared round unit
// depends on sha256s_pkg for constants, round table and round functions
`timescale 1ns / 1ps

// Usage
//   s_ channel: one beat per item. s_tuser = func (0 absorb, 1 finish),
//   s_tdata = message byte on absorb (ignored on finish).
//   m_ channel: eight beats per finish, one digest word each, most
//   significant word first; s_tuser-style index on m_tuser, m_tlast on
//   the eighth word.
// Timing
//   The 64th byte of a block starts the compression: the shared round
//   unit runs the rounds, then the working words are folded into the
//   chaining words.
//   A finish feeds padding and length bytes through the byte path one per
//   cycle (64 minus the fill level, at most 64; at most 72 with the extra
//   block), compresses, then offers the digest words one per cycle while
//   m_tready is high.
//   s_tready is low while a block compresses, while padding and while the
//   digest is waiting; a stalled receiver holds the current word stable.
// Reset
//   aresetn low (synchronous) loads the initial chaining values, clears the
//   bit count and the fill level and returns the core to accepting input.
module sha256_stream_hash_core
    import sha256s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] msg_byte
    input  logic [0:0]  s_tuser,    // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic [2:0]  m_tuser,    // [2:0] word_index
    output logic        m_tlast     // last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_ok_reg, len_ok_next;
    logic        finishing_reg, finishing_next;
    logic [63:0] bit_count_reg, bit_count_next;
    word_t       chain_reg [CHAIN_WORDS];
    word_t       chain_next [CHAIN_WORDS];
    word_t       w_reg [SCHED_WORDS];
    word_t       w_next [SCHED_WORDS];
    word_t       work_reg [CHAIN_WORDS];
    word_t       work_next [CHAIN_WORDS];

    logic        byte_en;
    logic [7:0]  byte_val;
    word_t       wt, t1, t2;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'd7);

    // shared round unit: schedule word and the two temporaries
    always_comb begin
        if (round_cnt_reg[5:4] == 2'b00) begin
            wt = w_reg[0];
        end else begin
            wt = small_s1(w_reg[14]) + w_reg[9] + small_s0(w_reg[1]) + w_reg[0];
        end
        t1 = work_reg[7] + big_s1(work_reg[4]) + ch_f(work_reg[4], work_reg[5], work_reg[6])
           + ROUND_K[round_cnt_reg] + wt;
        t2 = big_s0(work_reg[0]) + maj_f(work_reg[0], work_reg[1], work_reg[2]);
    end

    // sequencer and next-state logic
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        finishing_next = finishing_reg;
        bit_count_next = bit_count_reg;
        chain_next     = chain_reg;
        w_next         = w_reg;
        work_next      = work_reg;
        byte_en        = 1'b0;
        byte_val       = s_tdata;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == FUNC_FINISH) begin
                        state_next     = ST_PAD;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                        finishing_next = 1'b1;
                    end else begin
                        byte_en        = 1'b1;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                end
            end
            ST_PAD: begin
                byte_en = 1'b1;
                if (pad_first_reg) begin
                    // marker byte; length fits in this block if it lands below 56
                    byte_val       = PAD_BYTE;
                    pad_first_next = 1'b0;
                    len_ok_next    = (fill_reg < 6'(LEN_START));
                end else if (len_ok_reg && fill_reg >= 6'(LEN_START)) begin
                    // length bytes, most significant first
                    byte_val       = bit_count_reg[63:56];
                    bit_count_next = {bit_count_reg[55:0], 8'h00};
                end else begin
                    byte_val = 8'h00;
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[SCHED_WORDS-1] = wt;
                for (int j = 1; j < CHAIN_WORDS; j++) begin
                    work_next[j] = work_reg[j-1];
                end
                work_next[4]   = work_reg[3] + t1;
                work_next[0]   = t1 + t2;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int j = 0; j < CHAIN_WORDS; j++) begin
                    chain_next[j] = chain_reg[j] + work_reg[j];
                end
                if (finishing_reg && len_ok_reg) begin
                    state_next   = ST_OUT;
                    out_idx_next = 3'd0;
                end else if (finishing_reg) begin
                    // long tail: second block carries zeros and the length
                    state_next  = ST_PAD;
                    len_ok_next = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    for (int j = 0; j < CHAIN_WORDS - 1; j++) begin
                        chain_next[j] = chain_reg[j+1];
                    end
                    chain_next[CHAIN_WORDS-1] = chain_reg[0];
                    if (out_idx_reg == 3'd7) begin
                        chain_next     = INIT_HASH;
                        bit_count_next = '0;
                        finishing_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte path into the block buffer; a full block starts the rounds
        if (byte_en) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[SCHED_WORDS-1] = {w_reg[SCHED_WORDS-1][23:0], byte_val};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                state_next     = ST_ROUND;
                round_cnt_next = '0;
                work_next      = chain_reg;
            end
        end
    end

    // control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            finishing_reg <= 1'b0;
            bit_count_reg <= '0;
            chain_reg     <= INIT_HASH;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            finishing_reg <= finishing_next;
            bit_count_reg <= bit_count_next;
            chain_reg     <= chain_next;
        end
    end

    // block buffer / schedule window and working words
    always_ff @(posedge aclk) begin
        w_reg    <= w_next;
        work_reg <= work_next;
    end

    // input and output sides are never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest is offered");

    // rounds only start on a full block
    a_round_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("compression running with partial block");

    // last round hands over to the chaining add
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_cnt_reg == 6'(ROUNDS - 1)) |=> (state_reg == ST_ADD))
        else $error("round sequence did not end after the last round");

    // an absorb beat adds one byte to the length
    a_bit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == FUNC_ABSORB)
        |=> (bit_count_reg == $past(bit_count_reg) + 64'd8))
        else $error("bit count not advanced by an absorb beat");

    // after the last digest word the core is idle and reinitialized
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast)
        |=> (s_tready && bit_count_reg == 64'd0 && chain_reg[0] == INIT_HASH[0]))
        else $error("core not restarted after the last digest word");

endmodule
